// ===== design/swm_pkg.sv =====
// Shared types and constants for the sliding window median filter.
`default_nettype none

package swm_pkg;

  localparam int CFG_BITS       = 5;
  localparam int DEFAULT_WINDOW = 5;

  typedef struct packed {
    logic start;
    logic step;
    logic sign_step;
  } swm_ctl_t;

endpackage

`default_nettype wire

// ===== design/swm_ifs.sv =====
// Valid/ready channel interfaces for the sample and median streams.
`default_nettype none

interface swm_sample_if #(
  parameter int SAMPLE_BITS = 16
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface swm_median_if #(
  parameter int SAMPLE_BITS = 16
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] median;

  modport source (output valid, output median, input ready);
  modport sink   (input valid, input median, output ready);
endinterface

`default_nettype wire

// ===== design/swm_window.sv =====
// Circular window store of rotating shift registers with its write pointer.
`default_nettype none

module swm_window #(
  parameter int MAX_WINDOW  = 17,
  parameter int SAMPLE_BITS = 16,
  parameter int LW          = $clog2(MAX_WINDOW + 1)
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   clear,
  input  wire logic [LW-1:0]          len,
  input  wire logic                   wr_en,
  input  wire logic [SAMPLE_BITS-1:0] wr_data,
  input  wire logic                   rotate,
  output logic      [MAX_WINDOW-1:0]  msbs
);
  import swm_pkg::*;

  localparam int PW = $clog2(MAX_WINDOW);

  logic [SAMPLE_BITS-1:0] entries [MAX_WINDOW];
  logic [PW-1:0]          ptr;
  logic [LW-1:0]          ptr_inc;

  assign ptr_inc = LW'(ptr) + LW'(1);

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      ptr <= '0;
      for (int i = 0; i < MAX_WINDOW; i++) begin
        entries[i] <= '0;
      end
    end else if (wr_en) begin
      entries[ptr] <= wr_data;
      ptr          <= (ptr_inc >= len) ? '0 : PW'(ptr_inc);
    end else if (rotate) begin
      for (int i = 0; i < MAX_WINDOW; i++) begin
        entries[i] <= {entries[i][SAMPLE_BITS-2:0], entries[i][SAMPLE_BITS-1]};
      end
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_WINDOW; i++) begin
      msbs[i] = entries[i][SAMPLE_BITS-1];
    end
  end

  ptr_in_window: assert property (@(posedge clk) disable iff (rst)
    LW'(ptr) < len)
    else $error("write pointer outside active window");

endmodule

`default_nettype wire

// ===== design/swm_select.sv =====
// Bit-serial rank selection of the middle entry, most significant bit first.
`default_nettype none

module swm_select #(
  parameter int MAX_WINDOW  = 17,
  parameter int SAMPLE_BITS = 16,
  parameter int LW          = $clog2(MAX_WINDOW + 1)
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire swm_pkg::swm_ctl_t      ctl,
  input  wire logic [LW-1:0]          len,
  input  wire logic [MAX_WINDOW-1:0]  bits,
  output logic      [SAMPLE_BITS-1:0] result
);
  import swm_pkg::*;

  logic [MAX_WINDOW-1:0] cand;
  logic [MAX_WINDOW-1:0] mask;
  logic [MAX_WINDOW-1:0] match;
  logic [LW-1:0]         k;
  logic [LW-1:0]         count_low;
  logic                  low_bit;
  logic                  take_low;

  assign low_bit = ctl.sign_step;

  always_comb begin
    count_low = '0;
    for (int i = 0; i < MAX_WINDOW; i++) begin
      mask[i]   = (LW'(i) < len);
      match[i]  = cand[i] & (bits[i] == low_bit);
      count_low = count_low + LW'(match[i]);
    end
  end

  assign take_low = (k < count_low);

  always_ff @(posedge clk) begin
    if (rst) begin
      cand <= '0;
      k    <= '0;
    end else if (ctl.start) begin
      cand <= mask;
      k    <= len >> 1;
    end else if (ctl.step) begin
      if (take_low) begin
        cand <= match;
      end else begin
        cand <= cand & ~match;
        k    <= k - count_low;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.step) begin
      result <= {result[SAMPLE_BITS-2:0], take_low ? low_bit : ~low_bit};
    end
  end

  rank_covered: assert property (@(posedge clk) disable iff (rst)
    ctl.step |-> ($countones(cand) > int'(k)))
    else $error("candidate set cannot hold the target rank");

endmodule

`default_nettype wire

// ===== design/sliding_window_median.sv =====
// Sliding window median filter top level: control, configuration and output register.
// Sequence: an accepted request starts the bit-serial selection in ST_RUN, then ST_DONE loads
// the output register with the median once that register is free.
// A new request is taken only in ST_IDLE, after the one-bit-per-cycle pass of the selector
// and the load of the output register, which waits while an unaccepted median holds it.
// Reset: synchronous rst clears the window to zero, the pointer to 0, length to 5.
`default_nettype none

module sliding_window_median #(
  parameter int MAX_WINDOW  = 17,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [swm_pkg::CFG_BITS-1:0]    cfg_wdata,
  swm_sample_if.sink                           samples,
  swm_median_if.source                         medians
);
  import swm_pkg::*;

  localparam int LW = $clog2(MAX_WINDOW + 1);
  localparam int CW = $clog2(SAMPLE_BITS);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  function automatic logic [LW-1:0] norm_len(input logic [CFG_BITS-1:0] req);
    logic [6:0] n;
    n = 7'(req);
    if (n == 7'd0) n = 7'(DEFAULT_WINDOW);
    if (n > 7'(MAX_WINDOW)) n = 7'(MAX_WINDOW);
    if (!n[0]) n = n + 7'd1;
    if (n > 7'(MAX_WINDOW)) n = n - 7'd2;
    if (n == 7'd0) n = 7'd1;
    return LW'(n);
  endfunction

  state_t                 state;
  state_t                 state_next;
  logic [CW-1:0]          cnt;
  logic [LW-1:0]          len;
  logic                   accept;
  logic                   last;
  logic                   slot_free;
  logic                   out_valid;
  logic [SAMPLE_BITS-1:0] out_data;
  logic [SAMPLE_BITS-1:0] result;
  logic [MAX_WINDOW-1:0]  msbs;
  swm_ctl_t               ctl;

  assign samples.ready  = (state == ST_IDLE);
  assign accept         = samples.valid && samples.ready;
  assign last           = (cnt == CW'(SAMPLE_BITS - 1));
  assign slot_free      = !out_valid || medians.ready;
  assign medians.valid  = out_valid;
  assign medians.median = out_data;

  assign ctl.start     = accept;
  assign ctl.step      = (state == ST_RUN);
  assign ctl.sign_step = (cnt == '0);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) state_next = ST_RUN;
      end
      ST_RUN: begin
        if (last) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (slot_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      len       <= norm_len(CFG_BITS'(DEFAULT_WINDOW));
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        len <= norm_len(cfg_wdata);
      end
      if (state == ST_RUN) begin
        cnt <= last ? '0 : cnt + CW'(1);
      end
      if (state == ST_DONE && slot_free) begin
        out_valid <= 1'b1;
      end else if (medians.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && slot_free) begin
      out_data <= result;
    end
  end

  swm_window #(
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS),
    .LW          (LW)
  ) u_window (
    .clk     (clk),
    .rst     (rst),
    .clear   (cfg_we),
    .len     (len),
    .wr_en   (accept),
    .wr_data (samples.sample),
    .rotate  (state == ST_RUN),
    .msbs    (msbs)
  );

  swm_select #(
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS),
    .LW          (LW)
  ) u_select (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .len    (len),
    .bits   (msbs),
    .result (result)
  );

  run_ends: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN && last) |=> (state == ST_DONE))
    else $error("bit-serial pass did not end after the last bit");

  done_loads: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && slot_free) |=> (out_valid && state == ST_IDLE))
    else $error("median not loaded into the output register");

  idle_between: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> (cnt != '0 || $past(accept)))
    else $error("pass started without a request");

endmodule

`default_nettype wire

// ===== sim/swm_checker.sv =====
// Median checker: tracks the window, predicts each median and compares it with the block output.
module swm_checker #(
  parameter int MAX_WINDOW  = 17,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [swm_pkg::CFG_BITS-1:0]  cfg_wdata,
  input  wire logic                          in_valid,
  input  wire logic                          in_ready,
  input  wire logic signed [SAMPLE_BITS-1:0] in_sample,
  input  wire logic                          out_valid,
  input  wire logic                          out_ready,
  input  wire logic signed [SAMPLE_BITS-1:0] out_median,
  output int                                 pending,
  output int                                 fail_count
);
  import swm_pkg::*;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  sample_t     window [MAX_WINDOW];
  int unsigned wr_pos;
  int unsigned win_len;
  sample_t     exp_medians [$];
  sample_t     oldest;

  function automatic int unsigned norm_window_len(input logic [CFG_BITS-1:0] req);
    int unsigned n;
    n = req;
    if (n == 0) n = DEFAULT_WINDOW;
    if (n > MAX_WINDOW) n = MAX_WINDOW;
    if (n[0] == 1'b0) n++;
    if (n > MAX_WINDOW) n -= 2;
    if (n == 0) n = 1;
    return n;
  endfunction

  function automatic void clear_window();
    for (int i = 0; i < MAX_WINDOW; i++) window[i] = '0;
    wr_pos = 0;
  endfunction

  function automatic sample_t window_median();
    sample_t sorted [MAX_WINDOW];
    sample_t t;
    int      j;
    for (int i = 0; i < win_len; i++) sorted[i] = window[i];
    for (int i = 1; i < win_len; i++) begin
      t = sorted[i];
      j = i - 1;
      while (j >= 0 && sorted[j] > t) begin
        sorted[j + 1] = sorted[j];
        j--;
      end
      sorted[j + 1] = t;
    end
    return sorted[win_len / 2];
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      win_len = norm_window_len(CFG_BITS'(DEFAULT_WINDOW));
      clear_window();
      exp_medians.delete();
    end else begin
      if (cfg_we) begin
        win_len = norm_window_len(cfg_wdata);
        clear_window();
      end
      if (in_valid && in_ready) begin
        if (wr_pos >= win_len) wr_pos = 0;
        window[wr_pos] = in_sample;
        wr_pos = (wr_pos + 1 >= win_len) ? 0 : wr_pos + 1;
        exp_medians.push_back(window_median());
      end
      if (out_valid && out_ready) begin
        if (exp_medians.size() == 0) begin
          $error("median: unexpected result, expected none, actual %0d", out_median);
          fail_count++;
        end else begin
          oldest = exp_medians.pop_front();
          if (out_median !== oldest) begin
            $error("median: expected %0d, actual %0d", oldest, out_median);
            fail_count++;
          end
        end
      end
    end
    pending = exp_medians.size();
  end

endmodule

// ===== sim/sliding_window_median_tb.sv =====
// Testbench top for the sliding window median filter: clock, reset, requests and verdict.
module sliding_window_median_tb;
  import swm_pkg::*;

  localparam int MAX_WINDOW  = 17;
  localparam int SAMPLE_BITS = 16;
  localparam int PHASE_ITEMS = 150;
  localparam int NUM_PHASES  = 11;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  localparam sample_t DIRECTED [24] = '{
    16'sd32767, -16'sd32768, 16'sd0, -16'sd1, 16'sd1, 16'sd32767, 16'sd32767, 16'sd32767,
    -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768,
    16'sd100, 16'sd100, 16'sd100, 16'sd100, 16'sd100,
    16'sd1, 16'sd2, 16'sd3, 16'sd4, 16'sd5, -16'sd1
  };

  localparam logic [CFG_BITS-1:0] LEN_PLAN [NUM_PHASES] = '{
    5'd0, 5'd1, 5'd2, 5'd17, 5'd18, 5'd31, 5'd16, 5'd3, 5'd4, 5'd9, 5'd12
  };

  logic                clk = 1'b0;
  logic                rst;
  logic                cfg_we;
  logic [CFG_BITS-1:0] cfg_wdata;
  int                  send_idle_pct;
  int                  rcv_stall_pct;
  int                  pending;
  int                  mismatches;

  swm_sample_if #(.SAMPLE_BITS(SAMPLE_BITS)) samp_ch ();
  swm_median_if #(.SAMPLE_BITS(SAMPLE_BITS)) med_ch ();

  sliding_window_median #(
    .MAX_WINDOW (MAX_WINDOW),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .samples  (samp_ch),
    .medians  (med_ch)
  );

  swm_checker #(
    .MAX_WINDOW (MAX_WINDOW),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) chk (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (samp_ch.valid),
    .in_ready  (samp_ch.ready),
    .in_sample (samp_ch.sample),
    .out_valid (med_ch.valid),
    .out_ready (med_ch.ready),
    .out_median(med_ch.median),
    .pending   (pending),
    .fail_count(mismatches)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    med_ch.ready <= rst ? 1'b0 : (int'($urandom_range(99)) >= rcv_stall_pct);
  end

  task automatic set_idle_mode(input int mode);
    case (mode)
      0: begin send_idle_pct = 0;  rcv_stall_pct = 0;  end
      1: begin send_idle_pct = 46; rcv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  rcv_stall_pct = 46; end
      default: begin send_idle_pct = 18; rcv_stall_pct = 18; end
    endcase
  endtask

  task automatic send_sample(input sample_t s);
    while (int'($urandom_range(99)) < send_idle_pct) begin
      samp_ch.valid <= 1'b0;
      @(posedge clk);
    end
    samp_ch.valid  <= 1'b1;
    samp_ch.sample <= s;
    @(posedge clk);
    while (!samp_ch.ready) @(posedge clk);
  endtask

  // drop valid and hold until every median has come back
  task automatic drain();
    samp_ch.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  task automatic write_window_len(input logic [CFG_BITS-1:0] len);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= len;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic sample_t rand_sample();
    int sel;
    sel = $urandom_range(99);
    if (sel < 40) return sample_t'($urandom);
    if (sel < 65) return sample_t'(int'($urandom_range(8)) - 4);
    if (sel < 80) begin
      case ($urandom_range(3))
        0: return -16'sd32768;
        1: return -16'sd32767;
        2: return 16'sd32766;
        default: return 16'sd32767;
      endcase
    end
    return sample_t'(int'($urandom_range(2000)) - 1000);
  endfunction

  initial begin
    rst            = 1'b1;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    samp_ch.valid  = 1'b0;
    samp_ch.sample = '0;
    set_idle_mode(0);
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (DIRECTED[i]) send_sample(DIRECTED[i]);

    for (int p = 0; p < NUM_PHASES; p++) begin
      drain();
      set_idle_mode(p % 4);
      write_window_len((p == NUM_PHASES - 1) ? CFG_BITS'($urandom_range(31)) : LEN_PLAN[p]);
      repeat (PHASE_ITEMS) send_sample(rand_sample());
    end

    drain();
    repeat (SAMPLE_BITS + 4) @(posedge clk);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
